// File: design/fcu_pkg.sv
// ----------------------------------------------------------------------------
// fcu_pkg: shared types and constants for the fly camera update block
// Angle scales, CORDIC table, command codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package fcu_pkg;

	localparam int TRIG_STEPS = 16;
	localparam int IDX_W      = 5;

	localparam logic signed [19:0] HALF_TURN    = 20'sd184320;
	localparam logic signed [19:0] QUARTER_TURN = 20'sd92160;
	localparam logic [28:0]        FULL_TURN    = 29'd368640;
	localparam logic [28:0]        YAW_BIAS     = 29'd188743680; // 512 full turns
	localparam logic [3:0]         YMOD_TOP     = 4'd9;
	localparam logic [16:0]        PITCH_CAP    = 17'd91136;
	localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [15:0] UNIT_POS     = 16'sd16384;
	localparam logic signed [15:0] UNIT_NEG     = -16'sd16384;

	localparam logic signed [31:0] POS_Z_RESET  = 32'sd196608;
	localparam logic signed [18:0] YAW_RESET    = -19'sd92160;

	localparam logic [15:0] SPEED_RESET = 16'd384;
	localparam logic [11:0] SENS_RESET  = 12'd102;
	localparam logic [16:0] LIMIT_RESET = 17'd91136;

	localparam logic [1:0] CFG_MOVE_SPEED  = 2'd0;
	localparam logic [1:0] CFG_LOOK_SENS   = 2'd1;
	localparam logic [1:0] CFG_PITCH_LIMIT = 2'd2;

	localparam logic [2:0] CMD_LOOK    = 3'd0;
	localparam logic [2:0] CMD_FORWARD = 3'd1;
	localparam logic [2:0] CMD_BACK    = 3'd2;
	localparam logic [2:0] CMD_RIGHT   = 3'd3;
	localparam logic [2:0] CMD_LEFT    = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_YMUL, ST_YADD, ST_YMOD, ST_PMUL, ST_PCLAMP,
		ST_CYAW, ST_CPITCH, ST_FXM, ST_FXW, ST_FZM, ST_FZW,
		ST_RYAW, ST_MSD, ST_MSDL, ST_MMUL, ST_MACC, ST_DONE
	} fcu_state_t;

	typedef struct packed {
		logic              start;
		logic signed [19:0] angle;
	} fcu_trig_req_t;

	typedef struct packed {
		logic              done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} fcu_trig_rsp_t;

	// arctangent table, 1/65536 degree
	function automatic logic [22:0] fcu_atan(input logic [IDX_W-1:0] i);
		logic [22:0] r;
		case (i)
			5'd0:  r = 23'd2949120;
			5'd1:  r = 23'd1740967;
			5'd2:  r = 23'd919879;
			5'd3:  r = 23'd466945;
			5'd4:  r = 23'd234379;
			5'd5:  r = 23'd117304;
			5'd6:  r = 23'd58666;
			5'd7:  r = 23'd29335;
			5'd8:  r = 23'd14668;
			5'd9:  r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/fcu_if.sv
// ----------------------------------------------------------------------------
// fcu_if: event and result channels of the fly camera update block
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcu_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic [15:0]       frame_dt;
	logic signed [15:0] look_dx;
	logic signed [15:0] look_dy;

	modport source (output valid, command, frame_dt, look_dx, look_dy, input ready);
	modport sink   (input valid, command, frame_dt, look_dx, look_dy, output ready);
endinterface

interface fcu_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] front_x;
	logic signed [15:0] front_y;
	logic signed [15:0] front_z;
	logic signed [18:0] yaw_angle;
	logic signed [17:0] pitch_angle;

	modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		yaw_angle, pitch_angle, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		yaw_angle, pitch_angle, output ready);
endinterface

`default_nettype wire

// File: design/fcu_cordic.sv
// ----------------------------------------------------------------------------
// fcu_cordic: iterative sine/cosine unit
// Folds to +-90 degrees, then one CORDIC rotation per cycle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module fcu_cordic
	import fcu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  fcu_trig_req_t req,
	output fcu_trig_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [IDX_W-1:0]   i_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [25:0] z_q;

	logic signed [19:0] a_fold;
	logic               a_neg;
	logic signed [25:0] atan_v;
	logic signed [31:0] x_sh;
	logic signed [31:0] y_sh;

	always_comb begin
		a_fold = req.angle;
		a_neg  = 1'b0;
		if (req.angle > QUARTER_TURN) begin
			a_fold = req.angle - HALF_TURN;
			a_neg  = 1'b1;
		end else if (req.angle < -QUARTER_TURN) begin
			a_fold = req.angle + HALF_TURN;
			a_neg  = 1'b1;
		end
	end

	assign atan_v = $signed({3'b000, fcu_atan(i_q)});
	assign x_sh   = x_q >>> i_q;
	assign y_sh   = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == IDX_W'(TRIG_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= {a_fold, 6'b000000};
			neg_q <= a_neg;
			i_q   <= '0;
		end else if (busy_q) begin
			if (!z_q[25]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = neg_q ? -x_q : x_q;
	assign rsp.sin_v = neg_q ? -y_q : y_q;

endmodule

`default_nettype wire

// File: design/fly_camera_update.sv
// ----------------------------------------------------------------------------
// fly_camera_update: fixed-point Euler-angle fly camera
// Look runs the shared CORDIC unit twice (yaw, then pitch), right/left once;
// forward/back and unused codes do not use it. All but unused codes use the
// one shared multiplier. One event in flight; the next event is taken while
// a finished result still waits in the output register.
// Reset: asynchronous, active low; config, camera state, out valid to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module fly_camera_update
	import fcu_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	fcu_in_if.sink       req,
	fcu_out_if.source    rsp,
	input  wire logic    cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	// config registers
	logic [15:0] speed_q;
	logic [11:0] sens_q;
	logic [16:0] limit_q;

	// camera state
	logic signed [31:0] pos_q   [3];
	logic signed [15:0] front_q [3];
	logic signed [18:0] yaw_q;
	logic signed [17:0] pitch_q;

	// event transaction and work registers
	fcu_state_t         state_q, state_d;
	logic [2:0]         cmd_q;
	logic [15:0]        dt_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic [28:0]        yacc_q;
	logic [3:0]         k_q;
	logic signed [31:0] cy_q, sy_q, cp_q;
	logic signed [15:0] vec_q [3];
	logic [31:0]        sd_q;
	logic signed [65:0] mul_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] o_px_q, o_py_q, o_pz_q;
	logic signed [15:0] o_fx_q, o_fy_q, o_fz_q;
	logic signed [18:0] o_yaw_q;
	logic signed [17:0] o_pitch_q;

	fcu_trig_req_t trig_req;
	fcu_trig_rsp_t trig_rsp;
	logic          load_out;

	fcu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trig_req),
		.rsp    (trig_rsp)
	);

	// Q2.30 -> Q2.14, round and clamp to unit
	function automatic logic signed [15:0] q30_to_q14(input logic signed [32:0] v);
		logic signed [32:0] t;
		logic signed [15:0] r;
		t = (v + 33'sd32768) >>> 16;
		if (t > 33'sd16384)       r = UNIT_POS;
		else if (t < -33'sd16384) r = UNIT_NEG;
		else                      r = t[15:0];
		return r;
	endfunction

	// Q2.30 * Q2.30 -> Q2.14
	function automatic logic signed [15:0] prod_to_q14(input logic signed [65:0] p);
		logic signed [65:0] t;
		logic signed [15:0] r;
		t = (p + (66'sd1 <<< 45)) >>> 46;
		if (t > 66'sd16384)       r = UNIT_POS;
		else if (t < -66'sd16384) r = UNIT_NEG;
		else                      r = t[15:0];
		return r;
	endfunction

	// shared multiplier operand select
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_YMUL: begin
				mul_a = 33'(dx_q);
				mul_b = $signed({21'd0, sens_q});
			end
			ST_PMUL: begin
				mul_a = 33'(dy_q);
				mul_b = $signed({21'd0, sens_q});
			end
			ST_FXM: begin
				mul_a = 33'(cy_q);
				mul_b = 33'(cp_q);
			end
			ST_FZM: begin
				mul_a = 33'(sy_q);
				mul_b = 33'(cp_q);
			end
			ST_MSD: begin
				mul_a = $signed({17'd0, speed_q});
				mul_b = $signed({17'd0, dt_q});
			end
			ST_MMUL: begin
				mul_a = $signed({1'b0, sd_q});
				mul_b = 33'(vec_q[k_q[1:0]]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// yaw wrap: biased sum, then restoring subtract of FULL_TURN << k
	logic signed [30:0] yaw_sum;
	logic [28:0]        turn_sh;
	logic signed [19:0] yaw_unbias;
	assign yaw_sum    = 31'(yaw_q) + $signed(mul_q[30:0])
		+ $signed({2'b00, 29'(HALF_TURN)}) + $signed({2'b00, YAW_BIAS});
	assign turn_sh    = FULL_TURN << k_q;
	assign yaw_unbias = $signed({1'b0, yacc_q[18:0]}) - HALF_TURN;

	// pitch clamp
	logic [16:0]        lim;
	logic signed [30:0] pitch_sum;
	logic signed [30:0] lim_s;
	logic signed [17:0] pitch_new;
	assign lim       = (limit_q > PITCH_CAP) ? PITCH_CAP : limit_q;
	assign lim_s     = $signed({14'd0, lim});
	assign pitch_sum = 31'(pitch_q) + mul_q[30:0];
	always_comb begin
		if (pitch_sum > lim_s)       pitch_new = lim_s[17:0];
		else if (pitch_sum < -lim_s) pitch_new = 18'(-lim_s);
		else                         pitch_new = pitch_sum[17:0];
	end

	// move step: round to Q16.16, add or subtract, saturate
	logic               sub_mv;
	logic signed [65:0] d_mv;
	logic signed [65:0] n_mv;
	logic signed [31:0] n_sat;
	assign sub_mv = (cmd_q == CMD_BACK) || (cmd_q == CMD_LEFT);
	assign d_mv   = (mul_q + (66'sd1 <<< 21)) >>> 22;
	assign n_mv   = sub_mv ? 66'(pos_q[k_q[1:0]]) - d_mv : 66'(pos_q[k_q[1:0]]) + d_mv;
	always_comb begin
		if (n_mv > 66'sd2147483647)       n_sat = 32'sh7FFFFFFF;
		else if (n_mv < -66'sd2147483648) n_sat = 32'sh80000000;
		else                              n_sat = n_mv[31:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		trig_req.start = 1'b0;
		trig_req.angle = 20'(yaw_q);
		load_out       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.command) inside
						CMD_LOOK:             state_d = ST_YMUL;
						CMD_FORWARD, CMD_BACK: state_d = ST_MSD;
						CMD_RIGHT, CMD_LEFT: begin
							state_d        = ST_RYAW;
							trig_req.start = 1'b1;
						end
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_YMUL:   state_d = ST_YADD;
			ST_YADD:   state_d = ST_YMOD;
			ST_YMOD:   if (k_q == '0) state_d = ST_PMUL;
			ST_PMUL:   state_d = ST_PCLAMP;
			ST_PCLAMP: begin
				trig_req.start = 1'b1;
				state_d        = ST_CYAW;
			end
			ST_CYAW: begin
				if (trig_rsp.done) begin
					trig_req.start = 1'b1;
					trig_req.angle = 20'(pitch_q);
					state_d        = ST_CPITCH;
				end
			end
			ST_CPITCH: if (trig_rsp.done) state_d = ST_FXM;
			ST_FXM:    state_d = ST_FXW;
			ST_FXW:    state_d = ST_FZM;
			ST_FZM:    state_d = ST_FZW;
			ST_FZW:    state_d = ST_DONE;
			ST_RYAW:   if (trig_rsp.done) state_d = ST_MSD;
			ST_MSD:    state_d = ST_MSDL;
			ST_MSDL:   state_d = ST_MMUL;
			ST_MMUL:   state_d = ST_MACC;
			ST_MACC:   state_d = (k_q == 4'd2) ? ST_DONE : ST_MMUL;
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// config writes and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= SPEED_RESET;
			sens_q     <= SENS_RESET;
			limit_q    <= LIMIT_RESET;
			pos_q[0]   <= '0;
			pos_q[1]   <= '0;
			pos_q[2]   <= POS_Z_RESET;
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= UNIT_NEG;
			yaw_q      <= YAW_RESET;
			pitch_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_MOVE_SPEED:  speed_q <= cfg_data[15:0];
					CFG_LOOK_SENS:   sens_q  <= cfg_data[11:0];
					CFG_PITCH_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_PMUL:   yaw_q   <= yaw_unbias[18:0];
				ST_PCLAMP: pitch_q <= pitch_new;
				ST_CPITCH: if (trig_rsp.done) front_q[1] <= q30_to_q14(33'(trig_rsp.sin_v));
				ST_FXW:    front_q[0] <= prod_to_q14(mul_q);
				ST_FZW:    front_q[2] <= prod_to_q14(mul_q);
				ST_MACC:   pos_q[k_q[1:0]] <= n_sat;
				default: ;
			endcase
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cmd_q <= req.command;
					dt_q  <= req.frame_dt;
					dx_q  <= req.look_dx;
					dy_q  <= req.look_dy;
					vec_q <= front_q;
				end
			end
			ST_YADD: begin
				yacc_q <= yaw_sum[28:0];
				k_q    <= YMOD_TOP;
			end
			ST_YMOD: begin
				if (yacc_q >= turn_sh) yacc_q <= yacc_q - turn_sh;
				k_q <= k_q - 1'b1;
			end
			ST_CYAW: begin
				if (trig_rsp.done) begin
					cy_q <= trig_rsp.cos_v;
					sy_q <= trig_rsp.sin_v;
				end
			end
			ST_CPITCH: if (trig_rsp.done) cp_q <= trig_rsp.cos_v;
			ST_RYAW: begin
				if (trig_rsp.done) begin
					vec_q[0] <= q30_to_q14(-33'(trig_rsp.sin_v));
					vec_q[1] <= '0;
					vec_q[2] <= q30_to_q14(33'(trig_rsp.cos_v));
				end
			end
			ST_MSDL: begin
				sd_q <= mul_q[31:0];
				k_q  <= '0;
			end
			ST_MACC: k_q <= k_q + 1'b1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid_q <= 1'b0;
		else if (load_out)  out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_px_q    <= pos_q[0];
			o_py_q    <= pos_q[1];
			o_pz_q    <= pos_q[2];
			o_fx_q    <= front_q[0];
			o_fy_q    <= front_q[1];
			o_fz_q    <= front_q[2];
			o_yaw_q   <= yaw_q;
			o_pitch_q <= pitch_q;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.pos_x       = o_px_q;
	assign rsp.pos_y       = o_py_q;
	assign rsp.pos_z       = o_pz_q;
	assign rsp.front_x     = o_fx_q;
	assign rsp.front_y     = o_fy_q;
	assign rsp.front_z     = o_fz_q;
	assign rsp.yaw_angle   = o_yaw_q;
	assign rsp.pitch_angle = o_pitch_q;

endmodule

`default_nettype wire

// File: design/fcu_checker.sv
// ----------------------------------------------------------------------------
// fcu_checker: port-level assertions for fly_camera_update
// Result channel handshake, single event in flight, angle ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module fcu_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [18:0] yaw_angle,
	input wire logic signed [17:0] pitch_angle
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(pos_x) && $stable(yaw_angle))
		else $error("stalled result changed");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second event taken while busy");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (yaw_angle >= -19'sd184320) && (yaw_angle <= 19'sd184319))
		else $error("yaw outside wrap range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pitch_angle >= -18'sd91136) && (pitch_angle <= 18'sd91136))
		else $error("pitch outside cap");

endmodule

bind fly_camera_update fcu_checker u_fcu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.pos_x       (rsp.pos_x),
	.yaw_angle   (rsp.yaw_angle),
	.pitch_angle (rsp.pitch_angle)
);

`default_nettype wire
